// ===== sv/mwuf_pkg.sv =====
// ----------------------------------------------------------------------------
// Maze wall union-find package
// Shared widths, codes, queue entry and configuration types.
// ----------------------------------------------------------------------------
package mwuf_pkg;

   localparam int CELL_W    = 10;
   localparam int NUM_CELLS = 1024;
   localparam int DIM_W     = 6;
   localparam int MAX_DIM   = 32;
   localparam int TOTAL_W   = 11;
   localparam int REM_W     = 5;
   localparam int CNT_W     = 4;

   localparam logic [3:0] WALL_N    = 4'h1;
   localparam logic [3:0] WALL_E    = 4'h2;
   localparam logic [3:0] WALL_S    = 4'h4;
   localparam logic [3:0] WALL_W    = 4'h8;
   localparam logic [3:0] WALL_ALL  = 4'hF;
   localparam logic [3:0] RANK_MAX  = 4'd15;

   localparam logic CMD_OPEN = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [2:0] ST_OPENED    = 3'd0;
   localparam logic [2:0] ST_CONNECTED = 3'd1;
   localparam logic [2:0] ST_OFF_GRID  = 3'd2;
   localparam logic [2:0] ST_READ      = 3'd3;
   localparam logic [2:0] ST_RANGE     = 3'd4;

   localparam logic [1:0] REG_ROWS  = 2'd0;
   localparam logic [1:0] REG_COLS  = 2'd1;
   localparam logic [1:0] REG_START = 2'd2;
   localparam logic [1:0] REG_GOAL  = 2'd3;

   typedef enum logic [1:0] {DIR_NORTH, DIR_EAST, DIR_SOUTH, DIR_WEST} dir_type;

   typedef enum logic [1:0] {KIND_RANGE, KIND_READ, KIND_OFF, KIND_TRY} kind_type;

   typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} front_state_type;

   typedef enum logic [3:0] {
      B_CLEAR, B_IDLE, B_FIND_A, B_FIND_B, B_WALL_RD, B_WALL_CAP,
      B_WALL_WR, B_FIND_S, B_FIND_G, B_OUT
   } back_state_type;

   typedef struct packed {
      kind_type          kind;
      logic [CELL_W-1:0] cell_id;
      logic [CELL_W-1:0] nb;
      logic [3:0]        mine;
      logic [3:0]        theirs;
   } entry_type;

   typedef struct packed {
      logic [DIM_W-1:0]   cols;
      logic [TOTAL_W-1:0] total;
      logic [CELL_W-1:0]  start;
      logic [CELL_W-1:0]  goal;
   } cfg_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) r = DIM_W'(1);
      else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
      return r;
   endfunction

endpackage

// ===== sv/maze_wall_union_find_unit.sv =====
// ----------------------------------------------------------------------------
// Maze wall union-find unit
// Wall grid and union-find over cells for randomized maze carving.
// ----------------------------------------------------------------------------
// After reset the unit runs a clearing pass over its memories (walls
// closed, each cell its own parent, ranks zero) and holds req_stall high
// meanwhile. Each transaction then passes through the front, which derives
// the cell's column one quotient bit per cycle, and through the back, where
// each union-find walk steps through the single parent memory read port (up
// to four walks per item: cell, neighbor, start, goal), followed by the wall
// access, join and result. Front and back overlap through a two-entry queue,
// and the result register lets the next item proceed while a result waits to
// be taken.
// ----------------------------------------------------------------------------
module maze_wall_union_find_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_cmd,
   input  logic [mwuf_pkg::CELL_W-1:0]   req_cell_index,
   input  logic [1:0]                    req_direction,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [2:0]                    rsp_status,
   output logic [mwuf_pkg::CELL_W-1:0]   rsp_neighbor_index,
   output logic [3:0]                    rsp_cell_walls,
   output logic [3:0]                    rsp_neighbor_walls,
   output logic [mwuf_pkg::TOTAL_W-1:0]  rsp_component_count,
   output logic                          rsp_goal_connected,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [3:0]                    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   logic [mwuf_pkg::DIM_W-1:0]  rows_ff, cols_ff;
   logic [mwuf_pkg::CELL_W-1:0] start_ff, goal_ff;
   logic [mwuf_pkg::DIM_W-1:0]  rows_c, cols_c;
   logic [2*mwuf_pkg::DIM_W-1:0] prod;
   mwuf_pkg::cfg_type           cfg;
   logic                        wr_en;
   logic                        clear_busy;
   logic                        push, full, pop, empty;
   mwuf_pkg::entry_type         push_entry, head_entry;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= mwuf_pkg::DIM_W'(mwuf_pkg::MAX_DIM);
         cols_ff  <= mwuf_pkg::DIM_W'(mwuf_pkg::MAX_DIM);
         start_ff <= '0;
         goal_ff  <= '0;
      end else if (wr_en) begin
         case (paddr[3:2])
            mwuf_pkg::REG_ROWS:  rows_ff  <= pwdata[mwuf_pkg::DIM_W-1:0];
            mwuf_pkg::REG_COLS:  cols_ff  <= pwdata[mwuf_pkg::DIM_W-1:0];
            mwuf_pkg::REG_START: start_ff <= pwdata[mwuf_pkg::CELL_W-1:0];
            default:             goal_ff  <= pwdata[mwuf_pkg::CELL_W-1:0];
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         mwuf_pkg::REG_ROWS:  prdata = {{(32-mwuf_pkg::DIM_W){1'b0}}, rows_ff};
         mwuf_pkg::REG_COLS:  prdata = {{(32-mwuf_pkg::DIM_W){1'b0}}, cols_ff};
         mwuf_pkg::REG_START: prdata = {{(32-mwuf_pkg::CELL_W){1'b0}}, start_ff};
         default:             prdata = {{(32-mwuf_pkg::CELL_W){1'b0}}, goal_ff};
      endcase
   end

   assign rows_c = mwuf_pkg::clamp_dim(rows_ff);
   assign cols_c = mwuf_pkg::clamp_dim(cols_ff);
   assign prod   = {{mwuf_pkg::DIM_W{1'b0}}, rows_c} * {{mwuf_pkg::DIM_W{1'b0}}, cols_c};

   always_comb begin
      cfg.cols  = cols_c;
      cfg.total = (prod > (2*mwuf_pkg::DIM_W)'(mwuf_pkg::NUM_CELLS))
                  ? mwuf_pkg::TOTAL_W'(mwuf_pkg::NUM_CELLS)
                  : prod[mwuf_pkg::TOTAL_W-1:0];
      cfg.start = start_ff;
      cfg.goal  = goal_ff;
   end

   mwuf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .clear_busy     (clear_busy),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_cell_index (req_cell_index),
      .req_direction  (req_direction),
      .push           (push),
      .push_entry     (push_entry),
      .full           (full)
   );

   mwuf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .head_entry (head_entry),
      .empty      (empty)
   );

   mwuf_back u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .clear_busy          (clear_busy),
      .q_empty             (empty),
      .q_entry             (head_entry),
      .q_pop               (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_neighbor_index  (rsp_neighbor_index),
      .rsp_cell_walls      (rsp_cell_walls),
      .rsp_neighbor_walls  (rsp_neighbor_walls),
      .rsp_component_count (rsp_component_count),
      .rsp_goal_connected  (rsp_goal_connected)
   );

endmodule

// ===== sv/mwuf_queue.sv =====
// ----------------------------------------------------------------------------
// Maze wall union-find queue
// Two-entry queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module mwuf_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  mwuf_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output mwuf_pkg::entry_type head_entry,
   output logic                empty
);

   mwuf_pkg::entry_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign empty      = (count_ff == 2'd0);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== sv/mwuf_front.sv =====
// ----------------------------------------------------------------------------
// Maze wall union-find front
// Takes a transaction, finds the cell's column by shift-subtract division,
// classifies the move and queues it for the back.
// ----------------------------------------------------------------------------
module mwuf_front (
   input  logic                         clock,
   input  logic                         reset,
   input  mwuf_pkg::cfg_type            cfg,
   input  logic                         clear_busy,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_cmd,
   input  logic [mwuf_pkg::CELL_W-1:0]  req_cell_index,
   input  logic [1:0]                   req_direction,
   output logic                         push,
   output mwuf_pkg::entry_type          push_entry,
   input  logic                         full
);

   mwuf_pkg::front_state_type state_ff, state_in;
   logic                              cmd_ff;
   logic [mwuf_pkg::CELL_W-1:0]       cell_ff;
   mwuf_pkg::dir_type                 dir_ff;
   logic [mwuf_pkg::REM_W-1:0]        rem_ff, rem_in;
   logic [mwuf_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic                              accept;
   logic [mwuf_pkg::DIM_W-1:0]        shifted;
   logic [mwuf_pkg::TOTAL_W-1:0]      cell_x, cols_x, nb_x;
   logic                              off;

   assign accept  = req_valid && !req_stall;
   assign shifted = {rem_ff, cell_ff[cnt_ff]};
   assign cell_x  = {1'b0, cell_ff};
   assign cols_x  = {{(mwuf_pkg::TOTAL_W-mwuf_pkg::DIM_W){1'b0}}, cfg.cols};

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mwuf_pkg::F_IDLE: if (accept) state_in = mwuf_pkg::F_DIV;
         mwuf_pkg::F_DIV:  if (cnt_ff == '0) state_in = mwuf_pkg::F_PUSH;
         mwuf_pkg::F_PUSH: if (!full) state_in = mwuf_pkg::F_IDLE;
         default:          state_in = mwuf_pkg::F_IDLE;
      endcase
   end

   // Outputs and datapath.
   always_comb begin
      req_stall = (state_ff != mwuf_pkg::F_IDLE) || clear_busy;
      push      = (state_ff == mwuf_pkg::F_PUSH) && !full;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      if (state_ff == mwuf_pkg::F_IDLE) begin
         rem_in = '0;
         cnt_in = mwuf_pkg::CNT_W'(mwuf_pkg::CELL_W - 1);
      end else if (state_ff == mwuf_pkg::F_DIV) begin
         if (shifted >= cfg.cols) rem_in = mwuf_pkg::REM_W'(shifted - cfg.cols);
         else rem_in = shifted[mwuf_pkg::REM_W-1:0];
         cnt_in = cnt_ff - 1'b1;
      end
   end

   // Classification of the move.
   always_comb begin
      off               = 1'b0;
      nb_x              = '0;
      push_entry.mine   = mwuf_pkg::WALL_N;
      push_entry.theirs = mwuf_pkg::WALL_S;
      case (dir_ff)
         mwuf_pkg::DIR_NORTH: begin
            off  = cell_x < cols_x;
            nb_x = cell_x - cols_x;
         end
         mwuf_pkg::DIR_EAST: begin
            off               = ({1'b0, rem_ff} == cfg.cols - 1'b1);
            nb_x              = cell_x + 1'b1;
            push_entry.mine   = mwuf_pkg::WALL_E;
            push_entry.theirs = mwuf_pkg::WALL_W;
         end
         mwuf_pkg::DIR_SOUTH: begin
            off               = (cell_x + cols_x) >= cfg.total;
            nb_x              = cell_x + cols_x;
            push_entry.mine   = mwuf_pkg::WALL_S;
            push_entry.theirs = mwuf_pkg::WALL_N;
         end
         default: begin
            off               = (rem_ff == '0);
            nb_x              = cell_x - 1'b1;
            push_entry.mine   = mwuf_pkg::WALL_W;
            push_entry.theirs = mwuf_pkg::WALL_E;
         end
      endcase
      push_entry.cell_id = cell_ff;
      push_entry.nb      = nb_x[mwuf_pkg::CELL_W-1:0];
      if (cell_x >= cfg.total) push_entry.kind = mwuf_pkg::KIND_RANGE;
      else if (cmd_ff == mwuf_pkg::CMD_READ) push_entry.kind = mwuf_pkg::KIND_READ;
      else if (off || nb_x >= cfg.total) push_entry.kind = mwuf_pkg::KIND_OFF;
      else push_entry.kind = mwuf_pkg::KIND_TRY;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mwuf_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (accept) begin
         cmd_ff  <= req_cmd;
         cell_ff <= req_cell_index;
         dir_ff  <= mwuf_pkg::dir_type'(req_direction);
      end
   end

endmodule

// ===== sv/mwuf_back.sv =====
// ----------------------------------------------------------------------------
// Maze wall union-find back
// Owns the wall, parent and rank memories, walks parent chains, merges sets
// and holds the result register.
// ----------------------------------------------------------------------------
module mwuf_back (
   input  logic                          clock,
   input  logic                          reset,
   input  mwuf_pkg::cfg_type             cfg,
   output logic                          clear_busy,
   input  logic                          q_empty,
   input  mwuf_pkg::entry_type           q_entry,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [2:0]                    rsp_status,
   output logic [mwuf_pkg::CELL_W-1:0]   rsp_neighbor_index,
   output logic [3:0]                    rsp_cell_walls,
   output logic [3:0]                    rsp_neighbor_walls,
   output logic [mwuf_pkg::TOTAL_W-1:0]  rsp_component_count,
   output logic                          rsp_goal_connected
);

   localparam int CW = mwuf_pkg::CELL_W;

   logic [3:0]    wall_mem   [mwuf_pkg::NUM_CELLS];
   logic [CW-1:0] parent_mem [mwuf_pkg::NUM_CELLS];
   logic [3:0]    rank_mem   [mwuf_pkg::NUM_CELLS];

   mwuf_pkg::back_state_type state_ff, state_in;
   mwuf_pkg::entry_type      ent_ff, ent_in;
   logic                     pend_ff, pend_in;
   logic [CW-1:0]            walk_ff, walk_in;
   logic [CW-1:0]            ra_ff, ra_in, rb_ff, rb_in, rs_ff, rs_in;
   logic [CW-1:0]            clr_cnt_ff;
   logic [CW-1:0]            merge_ff, merge_in;
   logic [2:0]               status_ff, status_in;
   logic [CW-1:0]            nb_ff, nb_in;
   logic [3:0]               cw_ff, cw_in, nw_ff, nw_in;
   logic                     conn_ff, conn_in;

   logic                     out_valid_ff;
   logic [2:0]               out_status_ff;
   logic [CW-1:0]            out_nb_ff;
   logic [3:0]               out_cw_ff, out_nw_ff;
   logic [mwuf_pkg::TOTAL_W-1:0] out_comps_ff, comps;
   logic                     out_conn_ff;
   logic                     out_load;

   logic          w_we, p_we, r_we;
   logic [CW-1:0] w_waddr, p_waddr, r_waddr;
   logic [3:0]    w_wdata, r_wdata;
   logic [CW-1:0] p_wdata;
   logic [CW-1:0] w_raddr0, w_raddr1, r_raddr0, r_raddr1, p_raddr;
   logic [3:0]    w_rd0_ff, w_rd1_ff, r_rd0_ff, r_rd1_ff;
   logic [CW-1:0] p_rd_ff;

   logic          found, conn_ok, merge;
   logic [3:0]    cw_new, nw_new;

   assign found   = pend_ff && (p_rd_ff == walk_ff);
   assign conn_ok = ({1'b0, cfg.start} < cfg.total) && ({1'b0, cfg.goal} < cfg.total);
   assign merge   = (ent_ff.kind == mwuf_pkg::KIND_TRY) && (ra_ff != rb_ff);
   assign cw_new  = w_rd0_ff & ~ent_ff.mine;
   assign nw_new  = w_rd1_ff & ~ent_ff.theirs;
   assign comps   = ({1'b0, merge_ff} >= cfg.total) ? mwuf_pkg::TOTAL_W'(1)
                                                     : cfg.total - {1'b0, merge_ff};
   assign out_load   = (state_ff == mwuf_pkg::B_OUT) && (!out_valid_ff || !rsp_stall);
   assign clear_busy = (state_ff == mwuf_pkg::B_CLEAR);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mwuf_pkg::B_CLEAR: if (clr_cnt_ff == '1) state_in = mwuf_pkg::B_IDLE;
         mwuf_pkg::B_IDLE: begin
            if (!q_empty) begin
               unique case (q_entry.kind) inside
                  mwuf_pkg::KIND_TRY:                     state_in = mwuf_pkg::B_FIND_A;
                  mwuf_pkg::KIND_READ, mwuf_pkg::KIND_OFF: state_in = mwuf_pkg::B_WALL_RD;
                  default: state_in = conn_ok ? mwuf_pkg::B_FIND_S : mwuf_pkg::B_OUT;
               endcase
            end
         end
         mwuf_pkg::B_FIND_A:  if (found) state_in = mwuf_pkg::B_FIND_B;
         mwuf_pkg::B_FIND_B:  if (found) state_in = mwuf_pkg::B_WALL_RD;
         mwuf_pkg::B_WALL_RD: state_in = mwuf_pkg::B_WALL_CAP;
         mwuf_pkg::B_WALL_CAP: begin
            if (merge) state_in = mwuf_pkg::B_WALL_WR;
            else state_in = conn_ok ? mwuf_pkg::B_FIND_S : mwuf_pkg::B_OUT;
         end
         mwuf_pkg::B_WALL_WR: state_in = conn_ok ? mwuf_pkg::B_FIND_S : mwuf_pkg::B_OUT;
         mwuf_pkg::B_FIND_S:  if (found) state_in = mwuf_pkg::B_FIND_G;
         mwuf_pkg::B_FIND_G:  if (found) state_in = mwuf_pkg::B_OUT;
         mwuf_pkg::B_OUT:     if (out_load) state_in = mwuf_pkg::B_IDLE;
         default:             state_in = mwuf_pkg::B_IDLE;
      endcase
   end

   // Outputs and datapath.
   always_comb begin
      ent_in    = ent_ff;
      pend_in   = 1'b0;
      walk_in   = walk_ff;
      ra_in     = ra_ff;
      rb_in     = rb_ff;
      rs_in     = rs_ff;
      merge_in  = merge_ff;
      status_in = status_ff;
      nb_in     = nb_ff;
      cw_in     = cw_ff;
      nw_in     = nw_ff;
      conn_in   = conn_ff;
      q_pop     = 1'b0;
      w_we = 1'b0; p_we = 1'b0; r_we = 1'b0;
      w_waddr = ent_ff.cell_id; w_wdata = cw_new;
      p_waddr = ra_ff;          p_wdata = rb_ff;
      r_waddr = ra_ff;          r_wdata = r_rd0_ff + 1'b1;
      w_raddr0 = ent_ff.cell_id; w_raddr1 = ent_ff.nb;
      r_raddr0 = ra_ff;          r_raddr1 = rb_ff;
      p_raddr  = walk_ff;

      // One step of a parent walk: issue a read, then follow or stop.
      if (state_ff == mwuf_pkg::B_FIND_A || state_ff == mwuf_pkg::B_FIND_B ||
          state_ff == mwuf_pkg::B_FIND_S || state_ff == mwuf_pkg::B_FIND_G) begin
         if (!pend_ff) pend_in = 1'b1;
         else if (!found) walk_in = p_rd_ff;
      end

      unique case (state_ff)
         mwuf_pkg::B_CLEAR: begin
            w_we = 1'b1; p_we = 1'b1; r_we = 1'b1;
            w_waddr = clr_cnt_ff; p_waddr = clr_cnt_ff; r_waddr = clr_cnt_ff;
            w_wdata = mwuf_pkg::WALL_ALL; p_wdata = clr_cnt_ff; r_wdata = '0;
         end
         mwuf_pkg::B_IDLE: begin
            if (!q_empty) begin
               q_pop     = 1'b1;
               ent_in    = q_entry;
               walk_in   = q_entry.cell_id;
               status_in = mwuf_pkg::ST_RANGE;
               nb_in     = '0;
               cw_in     = '0;
               nw_in     = '0;
               conn_in   = 1'b0;
               if (q_entry.kind == mwuf_pkg::KIND_RANGE) walk_in = cfg.start;
            end
         end
         mwuf_pkg::B_FIND_A: begin
            if (found) begin
               ra_in   = walk_ff;
               walk_in = ent_ff.nb;
            end
         end
         mwuf_pkg::B_FIND_B: if (found) rb_in = walk_ff;
         mwuf_pkg::B_WALL_RD: ;
         mwuf_pkg::B_WALL_CAP: begin
            cw_in   = w_rd0_ff;
            walk_in = cfg.start;
            case (ent_ff.kind)
               mwuf_pkg::KIND_READ: status_in = mwuf_pkg::ST_READ;
               mwuf_pkg::KIND_OFF:  status_in = mwuf_pkg::ST_OFF_GRID;
               default: begin
                  nb_in = ent_ff.nb;
                  nw_in = w_rd1_ff;
                  if (merge) begin
                     status_in = mwuf_pkg::ST_OPENED;
                     cw_in     = cw_new;
                     nw_in     = nw_new;
                     merge_in  = merge_ff + 1'b1;
                     w_we      = 1'b1;
                     p_we      = 1'b1;
                     // Union by rank; the deeper root stays on top.
                     if (r_rd0_ff < r_rd1_ff) begin
                        p_waddr = ra_ff;
                        p_wdata = rb_ff;
                     end else begin
                        p_waddr = rb_ff;
                        p_wdata = ra_ff;
                        r_we    = (r_rd0_ff == r_rd1_ff) && (r_rd0_ff != mwuf_pkg::RANK_MAX);
                     end
                  end else begin
                     status_in = mwuf_pkg::ST_CONNECTED;
                  end
               end
            endcase
         end
         mwuf_pkg::B_WALL_WR: begin
            w_we    = 1'b1;
            w_waddr = ent_ff.nb;
            w_wdata = nw_ff;
            walk_in = cfg.start;
         end
         mwuf_pkg::B_FIND_S: begin
            if (found) begin
               rs_in   = walk_ff;
               walk_in = cfg.goal;
            end
         end
         mwuf_pkg::B_FIND_G: if (found) conn_in = (walk_ff == rs_ff);
         mwuf_pkg::B_OUT: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mwuf_pkg::B_CLEAR;
         clr_cnt_ff   <= '0;
         pend_ff      <= 1'b0;
         merge_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         pend_ff    <= pend_in;
         merge_ff   <= merge_in;
         if (out_load) out_valid_ff <= 1'b1;
         else if (!rsp_stall) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff    <= ent_in;
      walk_ff   <= walk_in;
      ra_ff     <= ra_in;
      rb_ff     <= rb_in;
      rs_ff     <= rs_in;
      status_ff <= status_in;
      nb_ff     <= nb_in;
      cw_ff     <= cw_in;
      nw_ff     <= nw_in;
      conn_ff   <= conn_in;
      if (out_load) begin
         out_status_ff <= status_ff;
         out_nb_ff     <= nb_ff;
         out_cw_ff     <= cw_ff;
         out_nw_ff     <= nw_ff;
         out_comps_ff  <= comps;
         out_conn_ff   <= conn_ff;
      end
   end

   // Memories.
   always_ff @(posedge clock) begin
      if (w_we) wall_mem[w_waddr] <= w_wdata;
      w_rd0_ff <= wall_mem[w_raddr0];
      w_rd1_ff <= wall_mem[w_raddr1];
   end

   always_ff @(posedge clock) begin
      if (p_we) parent_mem[p_waddr] <= p_wdata;
      p_rd_ff <= parent_mem[p_raddr];
   end

   always_ff @(posedge clock) begin
      if (r_we) rank_mem[r_waddr] <= r_wdata;
      r_rd0_ff <= rank_mem[r_raddr0];
      r_rd1_ff <= rank_mem[r_raddr1];
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_status          = out_status_ff;
   assign rsp_neighbor_index  = out_nb_ff;
   assign rsp_cell_walls      = out_cw_ff;
   assign rsp_neighbor_walls  = out_nw_ff;
   assign rsp_component_count = out_comps_ff;
   assign rsp_goal_connected  = out_conn_ff;

   merge_only_on_join: assert property (@(posedge clock) disable iff (reset)
      (state_ff != mwuf_pkg::B_WALL_CAP) |=> $stable(merge_ff))
      else $error("merge count changed outside a join");

   no_pop_while_clearing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mwuf_pkg::B_CLEAR) |-> !q_pop)
      else $error("queue popped during the clearing pass");

   idle_without_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mwuf_pkg::B_IDLE) |-> !pend_ff)
      else $error("parent read left pending in idle");

endmodule

// ===== tb/maze_wall_union_find_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Maze wall union-find unit testbench
// Drives wall-opening attempts and wall reads with random gaps on both sides,
// predicts each result with a behavioral union-find over a copy of the grid,
// and compares the results field by field. The grid registers are changed
// between phases, including the degenerate and oversized settings.
// ----------------------------------------------------------------------------
module maze_wall_union_find_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [2:0]  status;
      logic [9:0]  nb;
      logic [3:0]  cw;
      logic [3:0]  nw;
      logic [10:0] comps;
      logic        conn;
   } maze_result_type;

   typedef struct packed {
      logic       cmd;
      logic [9:0] cell_id;
      logic [1:0] dir;
   } maze_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_cmd = 1'b0;
   logic [9:0] req_cell_index = '0;
   logic [1:0] req_direction = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [2:0] rsp_status;
   logic [9:0] rsp_neighbor_index;
   logic [3:0] rsp_cell_walls;
   logic [3:0] rsp_neighbor_walls;
   logic [10:0] rsp_component_count;
   logic rsp_goal_connected;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [3:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   maze_wall_union_find_unit dut (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   // Predictor state.
   logic [5:0] grid_rows, grid_cols;
   logic [9:0] start_reg, goal_reg;
   logic [3:0] walls [mwuf_pkg::NUM_CELLS];
   logic [9:0] parent [mwuf_pkg::NUM_CELLS];
   logic [3:0] rank [mwuf_pkg::NUM_CELLS];
   int unsigned merges;

   maze_req_type    pending_reqs[$];
   maze_result_type expected_results[$];
   bit failed = 0;
   bit hold_receiver = 0;
   int unsigned idle_cycles = 0;

   function automatic int unsigned dim_used(logic [5:0] v);
      if (v == 0) return 1;
      if (v > mwuf_pkg::MAX_DIM) return mwuf_pkg::MAX_DIM;
      return v;
   endfunction

   function automatic int unsigned grid_cells();
      int unsigned n;
      n = dim_used(grid_rows) * dim_used(grid_cols);
      return (n > mwuf_pkg::NUM_CELLS) ? mwuf_pkg::NUM_CELLS : n;
   endfunction

   function automatic int unsigned root_of(int unsigned x);
      for (int s = 0; s < mwuf_pkg::NUM_CELLS; s++) begin
         if (parent[x] == x) break;
         x = parent[x];
      end
      return x;
   endfunction

   function automatic maze_result_type carve_step(maze_req_type q);
      maze_result_type r;
      int unsigned total, cols, c, nb, ra, rb;
      bit off;
      logic [3:0] mine, theirs;
      r = '0;
      total = grid_cells();
      cols = dim_used(grid_cols);
      c = q.cell_id;
      nb = 0;
      if (c >= total) r.status = mwuf_pkg::ST_RANGE;
      else if (q.cmd == mwuf_pkg::CMD_READ) begin
         r.status = mwuf_pkg::ST_READ;
         r.cw = walls[c];
      end else begin
         case (mwuf_pkg::dir_type'(q.dir))
            mwuf_pkg::DIR_NORTH: begin
               off = c < cols; nb = c - cols;
               mine = mwuf_pkg::WALL_N; theirs = mwuf_pkg::WALL_S;
            end
            mwuf_pkg::DIR_EAST: begin
               off = (c + 1) % cols == 0; nb = c + 1;
               mine = mwuf_pkg::WALL_E; theirs = mwuf_pkg::WALL_W;
            end
            mwuf_pkg::DIR_SOUTH: begin
               off = c + cols >= total; nb = c + cols;
               mine = mwuf_pkg::WALL_S; theirs = mwuf_pkg::WALL_N;
            end
            default: begin
               off = c % cols == 0; nb = c - 1;
               mine = mwuf_pkg::WALL_W; theirs = mwuf_pkg::WALL_E;
            end
         endcase
         if (off || nb >= total) begin
            r.status = mwuf_pkg::ST_OFF_GRID;
            r.cw = walls[c];
         end else begin
            ra = root_of(c);
            rb = root_of(nb);
            if (ra == rb) r.status = mwuf_pkg::ST_CONNECTED;
            else begin
               r.status = mwuf_pkg::ST_OPENED;
               walls[c] &= ~mine;
               walls[nb] &= ~theirs;
               if (rank[ra] < rank[rb]) parent[ra] = 10'(rb);
               else if (rank[ra] > rank[rb]) parent[rb] = 10'(ra);
               else begin
                  parent[rb] = 10'(ra);
                  if (rank[ra] < mwuf_pkg::RANK_MAX) rank[ra]++;
               end
               merges++;
            end
            r.nb = 10'(nb);
            r.cw = walls[c];
            r.nw = walls[nb];
         end
      end
      r.comps = 11'((merges >= total) ? 1 : total - merges);
      if (start_reg < total && goal_reg < total)
         r.conn = root_of(start_reg) == root_of(goal_reg);
      return r;
   endfunction

   // Driver: draws the next transaction from the pending queue after a random gap.
   int unsigned send_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_results.push_back(carve_step(
               maze_req_type'{req_cmd, req_cell_index, req_direction}));
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               maze_req_type q;
               q = pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_cmd <= q.cmd;
               req_cell_index <= q.cell_id;
               req_direction <= q.dir;
               send_gap <= ($urandom_range(0, 3) == 0) ?
                  (($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(1, 3)) : 0;
            end else req_valid <= 1'b0;
         end
      end
   end

   // Receiver stall and result checking.
   int unsigned stall_left = 0;
   bit stall_enable = 1;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result, status %0d", rsp_status);
               failed = 1;
            end else begin
               maze_result_type e;
               e = expected_results.pop_front();
               if (rsp_status !== e.status) begin
                  $error("status: expected %0d, got %0d", e.status, rsp_status); failed = 1;
               end
               if (rsp_neighbor_index !== e.nb) begin
                  $error("neighbor_index: expected %0d, got %0d", e.nb,
                         rsp_neighbor_index);
                  failed = 1;
               end
               if (rsp_cell_walls !== e.cw) begin
                  $error("cell_walls: expected %0h, got %0h", e.cw, rsp_cell_walls);
                  failed = 1;
               end
               if (rsp_neighbor_walls !== e.nw) begin
                  $error("neighbor_walls: expected %0h, got %0h", e.nw,
                         rsp_neighbor_walls);
                  failed = 1;
               end
               if (rsp_component_count !== e.comps) begin
                  $error("component_count: expected %0d, got %0d", e.comps,
                         rsp_component_count);
                  failed = 1;
               end
               if (rsp_goal_connected !== e.conn) begin
                  $error("goal_connected: expected %0d, got %0d", e.conn,
                         rsp_goal_connected);
                  failed = 1;
               end
            end
         end
         if (hold_receiver) rsp_stall <= 1'b1;
         else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
         end else if (stall_enable && $urandom_range(0, 4) == 0) begin
            stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else rsp_stall <= 1'b0;
      end
   end

   // Watchdog over cycles with no accepted transaction on either channel.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      @(posedge clock);
      psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         mwuf_pkg::REG_ROWS:  grid_rows = val[5:0];
         mwuf_pkg::REG_COLS:  grid_cols = val[5:0];
         mwuf_pkg::REG_START: start_reg = val[9:0];
         default:             goal_reg = val[9:0];
      endcase
   endtask

   task automatic wait_drained();
      wait (pending_reqs.size() == 0 && expected_results.size() == 0 && !req_valid);
      repeat (60) @(posedge clock);
   endtask

   task automatic push_req(logic cmd, logic [9:0] cell_id, logic [1:0] dir);
      pending_reqs.push_back(maze_req_type'{cmd, cell_id, dir});
   endtask

   // Mostly attempts on cells within the grid, some reads and stray cells.
   task automatic random_phase(int unsigned count);
      int unsigned total;
      total = grid_cells();
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) == 0)
            push_req(1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)),
                     2'($urandom_range(0, 3)));
         else
            push_req($urandom_range(0, 5) == 0, 10'($urandom_range(0, total - 1)),
                     2'($urandom_range(0, 3)));
      end
   endtask

   initial begin
      grid_rows = 32; grid_cols = 32; start_reg = 0; goal_reg = 0;
      for (int i = 0; i < mwuf_pkg::NUM_CELLS; i++) begin
         walls[i] = mwuf_pkg::WALL_ALL; parent[i] = 10'(i); rank[i] = 0;
      end
      merges = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: a 3x4 grid with every direction, edges, reads and out-of-range cells.
      csr_write(mwuf_pkg::REG_ROWS, 3);
      csr_write(mwuf_pkg::REG_COLS, 4);
      csr_write(mwuf_pkg::REG_START, 0);
      csr_write(mwuf_pkg::REG_GOAL, 11);
      push_req(mwuf_pkg::CMD_OPEN, 0, mwuf_pkg::DIR_NORTH);
      push_req(mwuf_pkg::CMD_OPEN, 0, mwuf_pkg::DIR_WEST);
      push_req(mwuf_pkg::CMD_OPEN, 3, mwuf_pkg::DIR_EAST);
      push_req(mwuf_pkg::CMD_OPEN, 8, mwuf_pkg::DIR_SOUTH);
      push_req(mwuf_pkg::CMD_OPEN, 0, mwuf_pkg::DIR_EAST);
      push_req(mwuf_pkg::CMD_OPEN, 1, mwuf_pkg::DIR_WEST);
      push_req(mwuf_pkg::CMD_OPEN, 1, mwuf_pkg::DIR_SOUTH);
      push_req(mwuf_pkg::CMD_OPEN, 9, mwuf_pkg::DIR_NORTH);
      push_req(mwuf_pkg::CMD_OPEN, 9, mwuf_pkg::DIR_EAST);
      push_req(mwuf_pkg::CMD_OPEN, 10, mwuf_pkg::DIR_EAST);
      push_req(mwuf_pkg::CMD_OPEN, 11, mwuf_pkg::DIR_NORTH);
      push_req(mwuf_pkg::CMD_READ, 5, mwuf_pkg::DIR_SOUTH);
      push_req(mwuf_pkg::CMD_READ, 11, mwuf_pkg::DIR_WEST);
      push_req(mwuf_pkg::CMD_READ, 12, mwuf_pkg::DIR_NORTH);
      push_req(mwuf_pkg::CMD_OPEN, 1023, mwuf_pkg::DIR_EAST);
      push_req(mwuf_pkg::CMD_OPEN, 2, mwuf_pkg::DIR_SOUTH);
      push_req(mwuf_pkg::CMD_OPEN, 6, mwuf_pkg::DIR_SOUTH);
      wait_drained();

      // Start beyond the grid, then a single-cell grid from zero sizes.
      csr_write(mwuf_pkg::REG_START, 1023);
      push_req(mwuf_pkg::CMD_OPEN, 4, mwuf_pkg::DIR_EAST);
      wait_drained();
      csr_write(mwuf_pkg::REG_ROWS, 0);
      csr_write(mwuf_pkg::REG_COLS, 0);
      csr_write(mwuf_pkg::REG_START, 0);
      csr_write(mwuf_pkg::REG_GOAL, 0);
      push_req(mwuf_pkg::CMD_OPEN, 0, mwuf_pkg::DIR_SOUTH);
      push_req(mwuf_pkg::CMD_READ, 0, mwuf_pkg::DIR_NORTH);
      push_req(mwuf_pkg::CMD_OPEN, 1, mwuf_pkg::DIR_NORTH);
      wait_drained();

      // Oversized dimensions clamp to a full grid; receiver holds long meanwhile.
      csr_write(mwuf_pkg::REG_ROWS, 63);
      csr_write(mwuf_pkg::REG_COLS, 63);
      csr_write(mwuf_pkg::REG_GOAL, 1023);
      hold_receiver = 1;
      random_phase(40);
      repeat (400) @(posedge clock);
      hold_receiver = 0;
      random_phase(400);
      wait_drained();

      // Small grids where carving completes and merges exceed the cell count.
      for (int p = 0; p < 6; p++) begin
         csr_write(mwuf_pkg::REG_ROWS, $urandom_range(1, 8));
         csr_write(mwuf_pkg::REG_COLS, $urandom_range(1, 8));
         csr_write(mwuf_pkg::REG_START, $urandom_range(0, 63));
         csr_write(mwuf_pkg::REG_GOAL, $urandom_range(0, 63));
         stall_enable = p[0];
         random_phase(150);
         wait_drained();
      end
      csr_write(mwuf_pkg::REG_ROWS, 32);
      csr_write(mwuf_pkg::REG_COLS, 1);
      random_phase(150);
      wait_drained();
      csr_write(mwuf_pkg::REG_ROWS, 1);
      csr_write(mwuf_pkg::REG_COLS, 32);
      random_phase(120);
      wait_drained();

      if (!failed) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end
endmodule

// ===== maze_wall_union_find_unit.f =====
sv/mwuf_pkg.sv
sv/mwuf_queue.sv
sv/mwuf_front.sv
sv/mwuf_back.sv
sv/maze_wall_union_find_unit.sv
tb/maze_wall_union_find_unit_tb.sv
